[rtl/v3g_pkg.sv]
// shared types, operation codes and trig constants for the 3d vector unit
// no dependencies; imported by vector3_geometry_alu_unit
package v3g_pkg;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_NEG    = 4'd2;
    localparam logic [3:0] OP_SCALE  = 4'd3;
    localparam logic [3:0] OP_DOT    = 4'd4;
    localparam logic [3:0] OP_CROSS  = 4'd5;
    localparam logic [3:0] OP_LEN    = 4'd6;
    localparam logic [3:0] OP_NORM   = 4'd7;
    localparam logic [3:0] OP_ROT_XY = 4'd8;
    localparam logic [3:0] OP_ROT_XZ = 4'd9;
    localparam logic [3:0] OP_ROT_YZ = 4'd10;
    localparam logic [3:0] OP_RAY    = 4'd11;

    localparam int unsigned TRIG_BITS = 30;
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam int unsigned TERMS     = 5;

    // series divisors and floor(2^32 / k)
    localparam logic [6:0]  SIN_DIV [TERMS] = '{7'd6, 7'd20, 7'd42, 7'd72, 7'd1};
    localparam logic [31:0] SIN_RCP [TERMS] = '{32'd715827882, 32'd214748364,
                                               32'd102261126, 32'd59652323,
                                               32'hffffffff};
    localparam logic [TERMS-1:0] SIN_ON = 5'b01111;
    localparam logic [6:0]  COS_DIV [TERMS] = '{7'd2, 7'd12, 7'd30, 7'd56, 7'd90};
    localparam logic [31:0] COS_RCP [TERMS] = '{32'd2147483648, 32'd357913941,
                                               32'd143165576, 32'd76695844,
                                               32'd47721858};

    typedef struct packed {
        logic        ov;
        logic [31:0] v;
    } t_sat;

    typedef struct packed {
        logic [2:0][31:0] v;
        logic [31:0]      scalar;
        logic             sat;
        logic             err;
    } t_res;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] a;
        t_res             res;
    } t_car;

    typedef struct packed {
        logic [29:0] x2;
        logic [30:0] s;
        logic [30:0] c;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [30:0] vs;
        logic [30:0] vc;
        logic [1:0]  quad;
        logic        swap;
    } t_trg;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_sqt;

    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat s;
        s.ov = 1'b0;
        s.v  = v[31:0];
        if (v > 66'sd2147483647) begin
            s.ov = 1'b1;
            s.v  = 32'h7fffffff;
        end else if (v < -66'sd2147483648) begin
            s.ov = 1'b1;
            s.v  = 32'h80000000;
        end
        return s;
    endfunction

    // floor((v + 2^(n-1)) / 2^n)
    function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                   input int unsigned n);
        logic signed [65:0] half;
        half = 66'sd1 <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

[rtl/vector3_geometry_alu_unit.sv]
// 3d vector unit in signed fixed point: add, sub, neg, scale, dot, cross,
// length, normalize, plane rotation and ray point, fully pipelined
// depends on v3g_pkg
//
// usage:
//   input channel i_valid / o_stall carries one item: operation, vectors a
//   and b, scale_factor and a binary angle. output channel o_valid / i_stall
//   returns one item per input item in order: r_x, r_y, r_z, r_scalar and
//   the saturated and zero_length_error flags.
//   an item passes FRAC_BITS + 38 register stages, a path length set by
//   the 32 stage square root and the FRAC_BITS + 1 stage divider of
//   normalize. every operation takes the same path length.
//   throughput is one item per cycle while the output is not stalled.
//   when the result at the output is stalled the whole pipeline holds and
//   o_stall rises in the same cycle; nothing is dropped or repeated.
//   reset clears all valid bits; payload registers are not reset.
module vector3_geometry_alu_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic signed [31:0] i_scale_factor,
    input  logic [15:0]        i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic signed [31:0] o_r_scalar,
    output logic               o_saturated,
    output logic               o_zero_length_error
);
    import v3g_pkg::*;

    localparam int DW     = 33 + FRAC_BITS;
    localparam int LAT    = 38 + FRAC_BITS;
    localparam int ST_LIN = 2;
    localparam int ST_MUL = 3;
    localparam int ST_ROT = 21;
    localparam int ST_LEN = 36;

    typedef struct packed {
        logic [DW-1:0]      rem;
        logic [FRAC_BITS:0] q;
    } t_div;

    logic             en;
    logic [LAT:1]     r_vld;
    t_car             r_car [1:LAT];
    t_car             n_car [1:LAT];
    logic [2:0][31:0] r_b;
    logic [31:0]      r_sf;
    logic [15:0]      r_ang;

    logic signed [31:0] m_x [6];
    logic signed [31:0] m_y [6];
    logic signed [63:0] r_p [6];
    logic [63:0]        r_sq;

    t_sat sv_add [3];
    t_sat sv_sub [3];
    t_sat sv_neg [3];
    t_sat sv_scl [3];
    t_sat sv_ray [3];
    t_sat sv_crs [3];
    t_sat sv_dot;
    t_sat sv_len;
    t_sat sv_rp;
    t_sat sv_rq;

    logic [13:0] tr_u;
    logic        tr_swp;
    logic [13:0] tr_w;
    logic [45:0] tr_prod;
    logic [29:0] r_tx;
    logic [1:0]  r_tq;
    logic        r_tsw;
    t_trg        r_trg [0:3*TERMS];
    t_trg        n_trg [0:3*TERMS];
    logic signed [31:0] tr_sv;
    logic signed [31:0] tr_cv;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;
    logic signed [31:0] rt_p;
    logic signed [31:0] rt_q;
    logic signed [63:0] r_rp [4];

    t_sqt        r_sqt [0:31];
    t_sqt        n_sqt [0:31];
    logic [32:0] n_len;
    logic [32:0] r_len;

    t_div        r_dv [0:FRAC_BITS][3];
    t_div        n_dv [0:FRAC_BITS][3];
    logic [32:0] r_dl [0:FRAC_BITS];
    logic        r_dz [0:FRAC_BITS];

    assign en      = !(r_vld[LAT] && i_stall);
    assign o_stall = !en;

    // ---------------- multiplier operand select
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            m_x[i] = '0;
            m_y[i] = '0;
        end
        case (r_car[1].op)
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = $signed(r_car[1].a[i]);
                    m_y[i] = $signed(r_sf);
                end
            end
            OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = $signed(r_car[1].a[i]);
                    m_y[i] = $signed(r_b[i]);
                end
            end
            OP_CROSS: begin
                m_x[0] = $signed(r_car[1].a[1]); m_y[0] = $signed(r_b[2]);
                m_x[1] = $signed(r_car[1].a[2]); m_y[1] = $signed(r_b[1]);
                m_x[2] = $signed(r_car[1].a[2]); m_y[2] = $signed(r_b[0]);
                m_x[3] = $signed(r_car[1].a[0]); m_y[3] = $signed(r_b[2]);
                m_x[4] = $signed(r_car[1].a[0]); m_y[4] = $signed(r_b[1]);
                m_x[5] = $signed(r_car[1].a[1]); m_y[5] = $signed(r_b[0]);
            end
            OP_LEN, OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = $signed(r_car[1].a[i]);
                    m_y[i] = $signed(r_car[1].a[i]);
                end
            end
            OP_RAY: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = $signed(r_b[i]);
                    m_y[i] = $signed(r_sf);
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    m_x[i] = $signed(r_car[1].a[i]);
                    m_y[i] = $signed(r_b[i]);
                end
            end
        endcase
    end

    // ---------------- saturating lanes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sv_add[i] = sat32(66'($signed(r_car[1].a[i])) + 66'($signed(r_b[i])));
            sv_sub[i] = sat32(66'($signed(r_car[1].a[i])) - 66'($signed(r_b[i])));
            sv_neg[i] = sat32(-66'($signed(r_car[1].a[i])));
            sv_scl[i] = sat32(rnd_shr(66'(r_p[i]), FRAC_BITS));
            sv_ray[i] = sat32(66'($signed(r_car[2].a[i])) +
                              rnd_shr(66'(r_p[i]), FRAC_BITS));
        end
        sv_crs[0] = sat32(rnd_shr(66'(r_p[0]) - 66'(r_p[1]), FRAC_BITS));
        sv_crs[1] = sat32(rnd_shr(66'(r_p[2]) - 66'(r_p[3]), FRAC_BITS));
        sv_crs[2] = sat32(rnd_shr(66'(r_p[4]) - 66'(r_p[5]), FRAC_BITS));
        sv_dot    = sat32(rnd_shr(66'(r_p[0]) + 66'(r_p[1]) + 66'(r_p[2]), FRAC_BITS));
        sv_len    = sat32(66'(n_len));
        sv_rp     = sat32(rnd_shr(66'(r_rp[0]) - 66'(r_rp[1]), TRIG_BITS));
        sv_rq     = sat32(rnd_shr(66'(r_rp[2]) + 66'(r_rp[3]), TRIG_BITS));
    end

    // ---------------- sine and cosine front end
    always_comb begin
        tr_u    = r_ang[13:0];
        tr_swp  = tr_u > 14'd8192;
        tr_w    = tr_swp ? 14'(15'd16384 - 15'(tr_u)) : tr_u;
        tr_prod = 46'(tr_w) * 46'(PI_Q30);
    end

    always_comb begin
        n_trg[0]      = '0;
        n_trg[0].x2   = 30'((60'(r_tx) * 60'(r_tx)) >> TRIG_BITS);
        n_trg[0].s    = 31'(r_tx);
        n_trg[0].ts   = 31'(r_tx);
        n_trg[0].c    = 31'(1) << TRIG_BITS;
        n_trg[0].tc   = 31'(1) << TRIG_BITS;
        n_trg[0].quad = r_tq;
        n_trg[0].swap = r_tsw;
    end

    for (genvar g = 1; g <= 3 * TERMS; g++) begin : g_trg
        localparam int TN = (g - 1) / 3;
        localparam int PH = (g - 1) % 3;
        logic [37:0] rs_s;
        logic [37:0] rs_c;
        logic [30:0] q_s;
        logic [30:0] q_c;
        always_comb begin
            n_trg[g] = r_trg[g-1];
            rs_s = 38'(r_trg[g-1].vs) - 38'(r_trg[g-1].ts) * 38'(SIN_DIV[TN]);
            rs_c = 38'(r_trg[g-1].vc) - 38'(r_trg[g-1].tc) * 38'(COS_DIV[TN]);
            q_s  = r_trg[g-1].ts + 31'(rs_s >= 38'(SIN_DIV[TN]));
            q_c  = r_trg[g-1].tc + 31'(rs_c >= 38'(COS_DIV[TN]));
            if (PH == 0) begin
                n_trg[g].ts = 31'((61'(r_trg[g-1].ts) * 61'(r_trg[g-1].x2)) >> TRIG_BITS);
                n_trg[g].tc = 31'((61'(r_trg[g-1].tc) * 61'(r_trg[g-1].x2)) >> TRIG_BITS);
            end else if (PH == 1) begin
                n_trg[g].vs = r_trg[g-1].ts;
                n_trg[g].vc = r_trg[g-1].tc;
                n_trg[g].ts = 31'((63'(r_trg[g-1].ts) * 63'(SIN_RCP[TN])) >> 32);
                n_trg[g].tc = 31'((63'(r_trg[g-1].tc) * 63'(COS_RCP[TN])) >> 32);
            end else begin
                n_trg[g].ts = q_s;
                n_trg[g].tc = q_c;
                if (SIN_ON[TN]) begin
                    n_trg[g].s = (TN % 2 == 0) ? r_trg[g-1].s - q_s : r_trg[g-1].s + q_s;
                end
                n_trg[g].c = (TN % 2 == 0) ? r_trg[g-1].c - q_c : r_trg[g-1].c + q_c;
            end
        end
    end

    always_comb begin
        tr_sv = r_trg[3*TERMS].swap ? 32'(r_trg[3*TERMS].c) : 32'(r_trg[3*TERMS].s);
        tr_cv = r_trg[3*TERMS].swap ? 32'(r_trg[3*TERMS].s) : 32'(r_trg[3*TERMS].c);
        case (r_car[19].op)
            OP_ROT_XZ: begin
                rt_p = $signed(r_car[19].a[0]);
                rt_q = $signed(r_car[19].a[2]);
            end
            OP_ROT_YZ: begin
                rt_p = $signed(r_car[19].a[1]);
                rt_q = $signed(r_car[19].a[2]);
            end
            default: begin
                rt_p = $signed(r_car[19].a[0]);
                rt_q = $signed(r_car[19].a[1]);
            end
        endcase
    end

    // ---------------- square root, one result bit per stage
    for (genvar g = 0; g < 32; g++) begin : g_sqt
        localparam int SH = 2 * (31 - g);
        t_sqt        cur;
        logic [63:0] one_bit;
        logic [64:0] trial;
        always_comb begin
            cur     = (g == 0) ? t_sqt'{rem: r_sq, root: 64'd0} : r_sqt[(g == 0) ? 0 : g-1];
            one_bit = 64'd1 << SH;
            trial   = 65'(cur.root) + 65'(one_bit);
            if (65'(cur.rem) >= trial) begin
                n_sqt[g].rem  = cur.rem - 64'(trial);
                n_sqt[g].root = (cur.root >> 1) + one_bit;
            end else begin
                n_sqt[g].rem  = cur.rem;
                n_sqt[g].root = cur.root >> 1;
            end
        end
    end

    assign n_len = 33'(r_sqt[31].root) + 33'(r_sqt[31].rem > r_sqt[31].root);

    // ---------------- normalize divider, one quotient bit per stage
    for (genvar g = 0; g <= FRAC_BITS; g++) begin : g_div
        localparam int SH = FRAC_BITS - g;
        t_div        cur [3];
        logic [32:0] dl;
        logic [DW-1:0] dvs;
        always_comb begin
            dl = (g == 0) ? r_len : r_dl[(g == 0) ? 0 : g-1];
            dvs = DW'(dl) << SH;
            for (int i = 0; i < 3; i++) begin
                if (g == 0) begin
                    cur[i].rem = (DW'(mag32(r_car[ST_LEN].a[i])) << FRAC_BITS) +
                                 DW'(r_len >> 1);
                    cur[i].q   = '0;
                end else begin
                    cur[i] = r_dv[(g == 0) ? 0 : g-1][i];
                end
                n_dv[g][i] = cur[i];
                if (cur[i].rem >= dvs) begin
                    n_dv[g][i].rem   = cur[i].rem - dvs;
                    n_dv[g][i].q[SH] = 1'b1;
                end
            end
        end
    end

    // ---------------- main item line with result merges
    always_comb begin
        n_car[1]    = '0;
        n_car[1].op = i_operation;
        n_car[1].a  = {i_a_z, i_a_y, i_a_x};
        for (int k = 2; k <= LAT; k++) begin
            n_car[k] = r_car[k-1];
        end

        for (int i = 0; i < 3; i++) begin
            case (r_car[ST_LIN-1].op)
                OP_ADD: begin
                    n_car[ST_LIN].res.v[i] = sv_add[i].v;
                    n_car[ST_LIN].res.sat  = n_car[ST_LIN].res.sat | sv_add[i].ov;
                end
                OP_SUB: begin
                    n_car[ST_LIN].res.v[i] = sv_sub[i].v;
                    n_car[ST_LIN].res.sat  = n_car[ST_LIN].res.sat | sv_sub[i].ov;
                end
                OP_NEG: begin
                    n_car[ST_LIN].res.v[i] = sv_neg[i].v;
                    n_car[ST_LIN].res.sat  = n_car[ST_LIN].res.sat | sv_neg[i].ov;
                end
                default: ;
            endcase
        end

        case (r_car[ST_MUL-1].op)
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_car[ST_MUL].res.v[i] = sv_scl[i].v;
                    n_car[ST_MUL].res.sat  = n_car[ST_MUL].res.sat | sv_scl[i].ov;
                end
            end
            OP_RAY: begin
                for (int i = 0; i < 3; i++) begin
                    n_car[ST_MUL].res.v[i] = sv_ray[i].v;
                    n_car[ST_MUL].res.sat  = n_car[ST_MUL].res.sat | sv_ray[i].ov;
                end
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_car[ST_MUL].res.v[i] = sv_crs[i].v;
                    n_car[ST_MUL].res.sat  = n_car[ST_MUL].res.sat | sv_crs[i].ov;
                end
            end
            OP_DOT: begin
                n_car[ST_MUL].res.scalar = sv_dot.v;
                n_car[ST_MUL].res.sat    = sv_dot.ov;
            end
            default: ;
        endcase

        case (r_car[ST_ROT-1].op)
            OP_ROT_XY: begin
                n_car[ST_ROT].res.v   = r_car[ST_ROT-1].a;
                n_car[ST_ROT].res.v[0] = sv_rp.v;
                n_car[ST_ROT].res.v[1] = sv_rq.v;
                n_car[ST_ROT].res.sat = sv_rp.ov | sv_rq.ov;
            end
            OP_ROT_XZ: begin
                n_car[ST_ROT].res.v   = r_car[ST_ROT-1].a;
                n_car[ST_ROT].res.v[0] = sv_rp.v;
                n_car[ST_ROT].res.v[2] = sv_rq.v;
                n_car[ST_ROT].res.sat = sv_rp.ov | sv_rq.ov;
            end
            OP_ROT_YZ: begin
                n_car[ST_ROT].res.v   = r_car[ST_ROT-1].a;
                n_car[ST_ROT].res.v[1] = sv_rp.v;
                n_car[ST_ROT].res.v[2] = sv_rq.v;
                n_car[ST_ROT].res.sat = sv_rp.ov | sv_rq.ov;
            end
            default: ;
        endcase

        if (r_car[ST_LEN-1].op == OP_LEN) begin
            n_car[ST_LEN].res.scalar = sv_len.v;
            n_car[ST_LEN].res.sat    = sv_len.ov;
        end

        if (r_car[LAT-1].op == OP_NORM) begin
            if (r_dz[FRAC_BITS]) begin
                n_car[LAT].res.err = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    n_car[LAT].res.v[i] = r_car[LAT-1].a[i][31] ?
                        -32'(r_dv[FRAC_BITS][i].q) : 32'(r_dv[FRAC_BITS][i].q);
                end
            end
        end
    end

    // ---------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 1; k <= LAT; k++) begin
                r_car[k] <= n_car[k];
            end
            r_b   <= {i_b_z, i_b_y, i_b_x};
            r_sf  <= i_scale_factor;
            r_ang <= i_angle;

            for (int i = 0; i < 6; i++) begin
                r_p[i] <= m_x[i] * m_y[i];
            end
            r_sq <= 64'(r_p[0]) + 64'(r_p[1]) + 64'(r_p[2]);

            r_tx  <= 30'((tr_prod + 46'd16384) >> 15);
            r_tq  <= r_ang[15:14];
            r_tsw <= tr_swp;
            for (int k = 0; k <= 3 * TERMS; k++) begin
                r_trg[k] <= n_trg[k];
            end
            case (r_trg[3*TERMS].quad)
                2'd0: begin
                    r_sin <= tr_sv;
                    r_cos <= tr_cv;
                end
                2'd1: begin
                    r_sin <= tr_cv;
                    r_cos <= -tr_sv;
                end
                2'd2: begin
                    r_sin <= -tr_sv;
                    r_cos <= -tr_cv;
                end
                default: begin
                    r_sin <= -tr_cv;
                    r_cos <= tr_sv;
                end
            endcase
            r_rp[0] <= rt_p * r_cos;
            r_rp[1] <= rt_q * r_sin;
            r_rp[2] <= rt_p * r_sin;
            r_rp[3] <= rt_q * r_cos;

            for (int k = 0; k < 32; k++) begin
                r_sqt[k] <= n_sqt[k];
            end
            r_len <= n_len;

            r_dl[0] <= r_len;
            r_dz[0] <= (r_len == 33'd0);
            for (int k = 1; k <= FRAC_BITS; k++) begin
                r_dl[k] <= r_dl[k-1];
                r_dz[k] <= r_dz[k-1];
            end
            for (int k = 0; k <= FRAC_BITS; k++) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    assign o_valid             = r_vld[LAT];
    assign o_r_x               = $signed(r_car[LAT].res.v[0]);
    assign o_r_y               = $signed(r_car[LAT].res.v[1]);
    assign o_r_z               = $signed(r_car[LAT].res.v[2]);
    assign o_r_scalar          = $signed(r_car[LAT].res.scalar);
    assign o_saturated         = r_car[LAT].res.sat;
    assign o_zero_length_error = r_car[LAT].res.err;

endmodule

[test/tb_top.sv]
// testbench for vector3_geometry_alu_unit: directed and random vector items
// checked field by field against an in-bench fixed point predictor
// depends on v3g_pkg and the rtl of vector3_geometry_alu_unit
module tb_top;
    import v3g_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a [3];
        logic [31:0] b [3];
        logic [31:0] sf;
        logic [15:0] angle;
    } vec_item_t;

    typedef struct {
        logic [31:0] r [3];
        logic [31:0] scalar;
        logic        sat;
        logic        err;
    } vec_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [3:0] i_operation = '0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [31:0] i_scale_factor = '0;
    logic [15:0] i_angle = '0;
    logic o_stall, o_valid, o_saturated, o_zero_length_error;
    logic signed [31:0] o_r_x, o_r_y, o_r_z, o_r_scalar;

    vec_item_t   pending_items [$];
    vec_result_t expected_results [$];
    int errors = 0;
    int sent_cnt = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;

    vector3_geometry_alu_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] clamp32(input wide_t v, inout bit flag);
        if (v > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic wide_t round_shr(input wide_t v, input int n);
        wide_t one;
        one = 1;
        return (v + (one <<< (n - 1))) >>> n;
    endfunction

    function automatic longint unsigned root_nearest(input longint unsigned n);
        longint unsigned res, bitv, rem;
        res = 0;
        bitv = 64'd1 << 62;
        rem = n;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (n - res * res > res) res++;
        return res;
    endfunction

    function automatic void sin_cos_q30(input logic [15:0] ang, output wide_t sn,
                                        output wide_t cs);
        longint unsigned u, w, x, x2, t, s, c, tc, pi, n;
        bit swap;
        wide_t sv, cv;
        pi = PI_Q30;
        u = ang[13:0];
        swap = u > 8192;
        w = swap ? 16384 - u : u;
        x = (w * pi + 16384) >> 15;
        x2 = (x * x) >> TRIG_BITS;
        t = x;
        s = x;
        for (n = 1; n <= 4; n++) begin
            t = ((t * x2) >> TRIG_BITS) / ((2 * n) * (2 * n + 1));
            s = n[0] ? s - t : s + t;
        end
        tc = 64'd1 << TRIG_BITS;
        c = tc;
        for (n = 1; n <= 5; n++) begin
            tc = ((tc * x2) >> TRIG_BITS) / ((2 * n - 1) * (2 * n));
            c = n[0] ? c - tc : c + tc;
        end
        sv = swap ? c : s;
        cv = swap ? s : c;
        case (ang[15:14])
            2'd0: begin sn = sv;  cs = cv;  end
            2'd1: begin sn = cv;  cs = -sv; end
            2'd2: begin sn = -sv; cs = -cv; end
            default: begin sn = -cv; cs = sv; end
        endcase
    endfunction

    function automatic vec_result_t predict_vector_op(input vec_item_t it);
        vec_result_t res;
        wide_t a [3], b [3], sf, sn, cs, p, q;
        longint unsigned m, sq, len, quo;
        bit sat;
        int pi, qi;
        sat = 1'b0;
        res.scalar = '0;
        res.err = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(it.a[i]);
            b[i] = $signed(it.b[i]);
            res.r[i] = '0;
        end
        sf = $signed(it.sf);
        case (it.op)
            OP_ADD: for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] + b[i], sat);
            OP_SUB: for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] - b[i], sat);
            OP_NEG: for (int i = 0; i < 3; i++) res.r[i] = clamp32(-a[i], sat);
            OP_SCALE:
                for (int i = 0; i < 3; i++) res.r[i] = clamp32(round_shr(a[i] * sf, 16), sat);
            OP_DOT:
                res.scalar = clamp32(round_shr(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 16),
                                     sat);
            OP_CROSS: begin
                res.r[0] = clamp32(round_shr(a[1] * b[2] - a[2] * b[1], 16), sat);
                res.r[1] = clamp32(round_shr(a[2] * b[0] - a[0] * b[2], 16), sat);
                res.r[2] = clamp32(round_shr(a[0] * b[1] - a[1] * b[0], 16), sat);
            end
            OP_LEN, OP_NORM: begin
                sq = 0;
                for (int i = 0; i < 3; i++) begin
                    m = 64'((a[i] < 0) ? -a[i] : a[i]);
                    sq += m * m;
                end
                len = root_nearest(sq);
                if (it.op == OP_LEN) begin
                    res.scalar = clamp32(len, sat);
                end else if (len == 0) begin
                    res.err = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        m = 64'((a[i] < 0) ? -a[i] : a[i]);
                        quo = ((m << 16) + len / 2) / len;
                        p = quo;
                        res.r[i] = clamp32((a[i] < 0) ? -p : p, sat);
                    end
                end
            end
            OP_ROT_XY, OP_ROT_XZ, OP_ROT_YZ: begin
                sin_cos_q30(it.angle, sn, cs);
                for (int i = 0; i < 3; i++) res.r[i] = it.a[i];
                pi = (it.op == OP_ROT_YZ) ? 1 : 0;
                qi = (it.op == OP_ROT_XY) ? 1 : 2;
                p = a[pi];
                q = a[qi];
                res.r[pi] = clamp32(round_shr(p * cs - q * sn, TRIG_BITS), sat);
                res.r[qi] = clamp32(round_shr(p * sn + q * cs, TRIG_BITS), sat);
            end
            OP_RAY:
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp32(a[i] + round_shr(b[i] * sf, 16), sat);
            default: ;
        endcase
        res.sat = sat;
        return res;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            2: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
            3: case ($urandom_range(4))
                0: return 32'h7fffffff;
                1: return 32'h80000000;
                2: return 32'hffffffff;
                3: return 32'h00000001;
                default: return 32'h0;
            endcase
            default: return $urandom_range(32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    task automatic add_item(input logic [3:0] op, input logic [31:0] av, input logic [31:0] bv,
                            input logic [31:0] sf, input logic [15:0] ang);
        vec_item_t it;
        it.op = op;
        it.a = '{av, -av, av ^ 32'h5a5a_0000};
        it.b = '{bv, bv + 32'h0001_0000, -bv};
        it.sf = sf;
        it.angle = ang;
        pending_items.push_back(it);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // sender: idle rate depends on the phase
    always @(posedge i_clk) begin
        int idle_pct;
        vec_item_t it;
        idle_pct = (sent_cnt < 430) ? 6 : (sent_cnt < 860) ? 54 : 0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                it = pending_items.pop_front();
                expected_results.push_back(predict_vector_op(it));
                i_operation <= it.op;
                i_a_x <= it.a[0];
                i_a_y <= it.a[1];
                i_a_z <= it.a[2];
                i_b_x <= it.b[0];
                i_b_y <= it.b[1];
                i_b_z <= it.b[2];
                i_scale_factor <= it.sf;
                i_angle <= it.angle;
                i_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    always @(posedge i_clk) begin
        if (!hold_done && sent_cnt >= 300) begin
            if (hold_cnt < 400) hold_cnt <= hold_cnt + 1;
            else hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        int idle_pct;
        vec_result_t want;
        idle_pct = (sent_cnt < 430) ? 54 : (sent_cnt < 860) ? 6 : 0;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected item", o_r_x, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (o_r_x !== want.r[0]) report("r_x", o_r_x, want.r[0]);
                if (o_r_y !== want.r[1]) report("r_y", o_r_y, want.r[1]);
                if (o_r_z !== want.r[2]) report("r_z", o_r_z, want.r[2]);
                if (o_r_scalar !== want.scalar) report("r_scalar", o_r_scalar, want.scalar);
                if (o_saturated !== want.sat) report("saturated", o_saturated, want.sat);
                if (o_zero_length_error !== want.err)
                    report("zero_length_error", o_zero_length_error, want.err);
            end
        end
        i_stall <= (sent_cnt >= 300 && !hold_done) || ($urandom_range(99) < idle_pct);
    end

    initial begin
        vec_item_t it;
        add_item(OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h0, 16'h0);
        add_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h0, 16'h0);
        add_item(OP_NEG, 32'h80000000, 32'h0, 32'h0, 16'h0);
        add_item(OP_SCALE, 32'h7fffffff, 32'h0, 32'h80000000, 16'h0);
        add_item(OP_SCALE, 32'h00018000, 32'h0, 32'hffff8000, 16'h0);
        add_item(OP_DOT, 32'h80000000, 32'h80000000, 32'h0, 16'h0);
        add_item(OP_DOT, 32'h00010000, 32'h00020000, 32'h0, 16'h0);
        add_item(OP_CROSS, 32'h7fffffff, 32'h80000000, 32'h0, 16'h0);
        add_item(OP_CROSS, 32'h00010000, 32'h00030000, 32'h0, 16'h0);
        add_item(OP_LEN, 32'h80000000, 32'h0, 32'h0, 16'h0);
        add_item(OP_LEN, 32'h00030000, 32'h0, 32'h0, 16'h0);
        add_item(OP_NORM, 32'h0, 32'h0, 32'h0, 16'h0);
        add_item(OP_NORM, 32'h00000001, 32'h0, 32'h0, 16'h0);
        add_item(OP_NORM, 32'h7fffffff, 32'h0, 32'h0, 16'h0);
        add_item(OP_ROT_XY, 32'h00010000, 32'h0, 32'h0, 16'h4000);
        add_item(OP_ROT_XY, 32'h80000000, 32'h0, 32'h0, 16'h2000);
        add_item(OP_ROT_XZ, 32'h7fffffff, 32'h0, 32'h0, 16'h8000);
        add_item(OP_ROT_YZ, 32'h00050000, 32'h0, 32'h0, 16'hffff);
        add_item(OP_ROT_YZ, 32'h00050000, 32'h0, 32'h0, 16'hc000);
        add_item(OP_RAY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0);
        add_item(OP_RAY, 32'h80000000, 32'h00010000, 32'hffff0000, 16'h0);
        add_item(4'd12, 32'h12345678, 32'h9abcdef0, 32'h1, 16'h1234);
        add_item(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
        for (int k = 0; k < 1300; k++) begin
            it.op = 4'(($urandom_range(19) == 0) ? $urandom_range(15, 12) : $urandom_range(11));
            for (int i = 0; i < 3; i++) begin
                it.a[i] = pick_value();
                it.b[i] = pick_value();
            end
            if ($urandom_range(9) == 0) it.a = '{32'h0, 32'h0, 32'h0};
            it.sf = pick_value();
            it.angle = 16'($urandom);
            pending_items.push_back(it);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (80) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("vector3_geometry_alu_unit: match");
        else
            $display("vector3_geometry_alu_unit: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("vector3_geometry_alu_unit: mismatch");
        $finish;
    end

endmodule
